[rtl/core/lmi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmi_pkg
// Shared widths, constants and types for the linear move interpolator.
// ----------------------------------------------------------------------------
package lmi_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int POS_W       = 27;
  localparam int TURN_W      = 20;
  localparam int ACC_W       = 32;
  localparam int STEP_LEN_W  = 21;
  localparam int COUNT_W     = 16;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 80;
  localparam int DIV_CNT_W   = $clog2(ACC_W + 1);

  localparam logic [STEP_LEN_W-1:0] STEP_LEN_RESET = STEP_LEN_W'(1 << (FRAC_BITS - 1));

  typedef struct packed {
    logic                  start;
    logic [ACC_W-1:0]      dividend;
    logic [STEP_LEN_W-1:0] divisor;
  } div_req_t;

endpackage

[rtl/core/lmi_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmi_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lmi_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lmi_pkg::div_req_t       req,
  output logic                    done,
  output logic [lmi_pkg::ACC_W-1:0] quotient
);
  import lmi_pkg::*;

  logic [STEP_LEN_W-1:0] rem_r;
  logic [ACC_W-1:0]      quo_r;
  logic [STEP_LEN_W-1:0] dvs_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic                  done_r;
  logic [STEP_LEN_W:0]   trial;
  logic                  fits;

  assign trial = {rem_r, quo_r[ACC_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      quo_r  <= '0;
      dvs_r  <= '0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= !req.start && (cnt_r == DIV_CNT_W'(1));
      if (req.start) begin
        rem_r <= '0;
        quo_r <= req.dividend;
        dvs_r <= req.divisor;
        cnt_r <= DIV_CNT_W'(ACC_W);
      end else if (cnt_r != '0) begin
        rem_r <= fits ? STEP_LEN_W'(trial - {1'b0, dvs_r}) : trial[STEP_LEN_W-1:0];
        quo_r <= {quo_r[ACC_W-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[rtl/core/linear_move_interpolator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_move_interpolator
// Moves a Q16.16 setpoint toward each commanded target in equal steps.
// ----------------------------------------------------------------------------
// One request is taken at a time; in_tready is high only while the block is
// idle. A tick that needs no replanning hands off at most two results. A
// tick with a new target replans through one shared 32-bit divider used four
// times (step count, then the reach, height and turn increments). Results sit
// in an output register, so a request is accepted while the last result is
// still waiting for out_tready.
module linear_move_interpolator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [lmi_pkg::STEP_LEN_W-1:0]      cfg_wdata,   // step_length
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // target_reach[26:0], target_height[53:27], target_turn[73:54],
  // allow[74], restart[75], servos_moving[76], zero[79:77]
  input  logic [lmi_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // set_reach[26:0], set_height[53:27], set_turn[73:54], zero[79:74]
  output logic [lmi_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                out_tuser,   // in_motion
  output logic                                out_tlast    // last
);
  import lmi_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_EVAL, S_DIFF, S_NSTART, S_DIV_N, S_DIV_R, S_DIV_H, S_DIV_T, S_STEP, S_EMIT
  } state_t;

  state_t state_r;

  logic [STEP_LEN_W-1:0] step_len_r;
  logic [ACC_W-1:0] tr_r, th_r, tt_r;
  logic allow_r, busy_r;
  logic [ACC_W-1:0] now_r_r, now_h_r, now_t_r;
  logic [ACC_W-1:0] plan_r_r, plan_h_r, plan_t_r;
  logic [ACC_W-1:0] inc_r_r, inc_h_r, inc_t_r;
  logic [ACC_W:0]   dr_r, dh_r, dt_r;
  logic [COUNT_W-1:0] steps_r;
  logic first_r, mf_r;
  logic [ACC_W-1:0] res_r_r, res_h_r, res_t_r;
  logic res_mot_r, res_last_r, snap_r;
  logic out_valid_r, out_mot_r, out_last_r;
  logic [ACC_W-1:0] out_r_r, out_h_r, out_t_r;
  div_req_t div_req_r;
  logic div_done;
  logic [ACC_W-1:0] div_q;

  logic out_free;
  logic [STEP_LEN_W-1:0] sl;
  logic [ACC_W-1:0] mr, mh, mt, dist_mag;
  logic [COUNT_W-1:0] n_sat, steps_dec;
  logic [ACC_W-1:0] nr, nh, nt;

  function automatic logic [ACC_W-1:0] mag(input logic [ACC_W:0] d);
    mag = d[ACC_W] ? ACC_W'(-d) : d[ACC_W-1:0];
  endfunction

  function automatic logic [ACC_W-1:0] signq(input logic neg, input logic [ACC_W-1:0] q);
    signq = neg ? ACC_W'(-q) : q;
  endfunction

  lmi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign sl        = (step_len_r == '0) ? STEP_LEN_W'(1) : step_len_r;
  assign mr        = mag(dr_r);
  assign mh        = mag(dh_r);
  assign mt        = mag(dt_r);
  assign dist_mag  = (mr == '0 && mh == '0) ? mt : ((mh > mr) ? mh : mr);
  assign n_sat     = (div_q[ACC_W-1:COUNT_W] != '0) ? '1 :
                     (div_q[COUNT_W-1:0] == '0) ? COUNT_W'(1) : div_q[COUNT_W-1:0];
  assign steps_dec = (steps_r == '0) ? '0 : steps_r - 1'b1;
  assign nr        = now_r_r + inc_r_r;
  assign nh        = now_h_r + inc_h_r;
  assign nt        = now_t_r + inc_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_len_r  <= STEP_LEN_RESET;
      tr_r        <= '0;
      th_r        <= '0;
      tt_r        <= '0;
      allow_r     <= 1'b0;
      busy_r      <= 1'b0;
      now_r_r     <= '0;
      now_h_r     <= '0;
      now_t_r     <= '0;
      plan_r_r    <= '0;
      plan_h_r    <= '0;
      plan_t_r    <= '0;
      inc_r_r     <= '0;
      inc_h_r     <= '0;
      inc_t_r     <= '0;
      dr_r        <= '0;
      dh_r        <= '0;
      dt_r        <= '0;
      steps_r     <= '0;
      first_r     <= 1'b1;
      mf_r        <= 1'b0;
      res_r_r     <= '0;
      res_h_r     <= '0;
      res_t_r     <= '0;
      res_mot_r   <= 1'b0;
      res_last_r  <= 1'b0;
      snap_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_mot_r   <= 1'b0;
      out_last_r  <= 1'b0;
      out_r_r     <= '0;
      out_h_r     <= '0;
      out_t_r     <= '0;
      div_req_r   <= '0;
    end else begin
      if (cfg_we) begin
        step_len_r <= cfg_wdata;
      end
      if (state_r == S_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      div_req_r.start <= (state_r == S_NSTART) ||
                         (div_done && (state_r inside {S_DIV_N, S_DIV_R, S_DIV_H}));

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            tr_r    <= ACC_W'($signed(in_tdata[POS_W-1:0]));
            th_r    <= ACC_W'($signed(in_tdata[2*POS_W-1:POS_W]));
            tt_r    <= ACC_W'($signed(in_tdata[2*POS_W+TURN_W-1:2*POS_W]));
            allow_r <= in_tdata[2*POS_W+TURN_W];
            busy_r  <= in_tdata[2*POS_W+TURN_W+2];
            if (in_tdata[2*POS_W+TURN_W+1]) begin
              first_r <= 1'b1;
              mf_r    <= 1'b0;
            end
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (tr_r == '0 || th_r == '0 || tt_r == '0) begin
            state_r <= S_IDLE;
          end else if (first_r) begin
            if (!busy_r) begin
              now_r_r  <= tr_r;
              now_h_r  <= th_r;
              now_t_r  <= tt_r;
              plan_r_r <= tr_r;
              plan_h_r <= th_r;
              plan_t_r <= tt_r;
              first_r  <= 1'b0;
              mf_r     <= 1'b0;
            end
            res_r_r    <= tr_r;
            res_h_r    <= th_r;
            res_t_r    <= tt_r;
            res_mot_r  <= busy_r & mf_r;
            res_last_r <= 1'b1;
            snap_r     <= 1'b0;
            state_r    <= S_EMIT;
          end else if (!allow_r || (tr_r == now_r_r && th_r == now_h_r && tt_r == now_t_r)) begin
            mf_r    <= 1'b0;
            state_r <= S_IDLE;
          end else begin
            mf_r <= 1'b1;
            if (tr_r != plan_r_r || th_r != plan_h_r || tt_r != plan_t_r) begin
              plan_r_r <= tr_r;
              plan_h_r <= th_r;
              plan_t_r <= tt_r;
              state_r  <= S_DIFF;
            end else begin
              state_r <= S_STEP;
            end
          end
        end
        S_DIFF: begin
          dr_r    <= {tr_r[ACC_W-1], tr_r} - {now_r_r[ACC_W-1], now_r_r};
          dh_r    <= {th_r[ACC_W-1], th_r} - {now_h_r[ACC_W-1], now_h_r};
          dt_r    <= {tt_r[ACC_W-1], tt_r} - {now_t_r[ACC_W-1], now_t_r};
          state_r <= S_NSTART;
        end
        S_NSTART: begin
          div_req_r.dividend <= dist_mag;
          div_req_r.divisor  <= sl;
          state_r            <= S_DIV_N;
        end
        S_DIV_N: begin
          if (div_done) begin
            steps_r            <= n_sat;
            div_req_r.dividend <= mr;
            div_req_r.divisor  <= STEP_LEN_W'(n_sat);
            state_r            <= S_DIV_R;
          end
        end
        S_DIV_R: begin
          if (div_done) begin
            inc_r_r            <= signq(dr_r[ACC_W], div_q);
            div_req_r.dividend <= mh;
            div_req_r.divisor  <= STEP_LEN_W'(steps_r);
            state_r            <= S_DIV_H;
          end
        end
        S_DIV_H: begin
          if (div_done) begin
            inc_h_r            <= signq(dh_r[ACC_W], div_q);
            div_req_r.dividend <= mt;
            div_req_r.divisor  <= STEP_LEN_W'(steps_r);
            state_r            <= S_DIV_T;
          end
        end
        S_DIV_T: begin
          if (div_done) begin
            inc_t_r <= signq(dt_r[ACC_W], div_q);
            state_r <= S_STEP;
          end
        end
        S_STEP: begin
          steps_r   <= steps_dec;
          res_r_r   <= nr;
          res_h_r   <= nh;
          res_t_r   <= nt;
          res_mot_r <= 1'b1;
          if (steps_dec <= COUNT_W'(1)) begin
            res_last_r <= 1'b0;
            snap_r     <= 1'b1;
            now_r_r    <= tr_r;
            now_h_r    <= th_r;
            now_t_r    <= tt_r;
            plan_r_r   <= tr_r;
            plan_h_r   <= th_r;
            plan_t_r   <= tt_r;
            mf_r       <= 1'b0;
          end else begin
            res_last_r <= 1'b1;
            snap_r     <= 1'b0;
            now_r_r    <= nr;
            now_h_r    <= nh;
            now_t_r    <= nt;
          end
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_r_r     <= res_r_r;
            out_h_r     <= res_h_r;
            out_t_r     <= res_t_r;
            out_mot_r   <= res_mot_r;
            out_last_r  <= res_last_r;
            if (snap_r) begin
              res_r_r    <= tr_r;
              res_h_r    <= th_r;
              res_t_r    <= tt_r;
              res_mot_r  <= 1'b0;
              res_last_r <= 1'b1;
              snap_r     <= 1'b0;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - 2*POS_W - TURN_W)'(0), out_t_r[TURN_W-1:0],
                       out_h_r[POS_W-1:0], out_r_r[POS_W-1:0]};
  assign out_tuser  = out_mot_r;
  assign out_tlast  = out_last_r;

endmodule

[rtl/core/lmi_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmi_checker
// Port-level checks for the linear move interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module lmi_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [lmi_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input logic                                out_tuser,
  input logic                                out_tlast
);

  // one request at a time
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("in_tready high right after a request");

  // a non-final result is always an interpolated step
  a_mid_in_motion: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser)
    else $error("non-final result without in_motion");

  // the snap result follows the intermediate one with no gap
  a_snap_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && out_tlast)
    else $error("snap result did not follow");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

endmodule

bind linear_move_interpolator lmi_checker u_lmi_checker (.*);
